### rtl/pidcs_pkg.sv
package pidcs_pkg;

    // configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INT_GAIN   = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_MIN    = 3'd3,
        REG_OUT_MAX    = 3'd4,
        REG_P_ON_MEAS  = 3'd5
    } reg_idx_t;

    localparam logic signed [15:0] OUT_MAX_RESET = 16'sd32767;

    typedef struct packed {
        logic signed [15:0] measurement;
        logic signed [15:0] setpoint;
        logic               auto_enable;
        logic signed [15:0] manual_output;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               limited;
    } result_t;

    // register file contents as seen by the datapath
    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] int_gain;
        logic signed [31:0] deriv_gain;
        logic signed [15:0] out_min;
        logic signed [15:0] out_max;
        logic               p_on_measurement;
        logic               limits_written;
    } cfg_regs_t;

endpackage

### rtl/pidcs_cfg.sv
module pidcs_cfg
    import pidcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_regs_t             cfg
);

    logic signed [31:0] prop_gain_reg;
    logic signed [31:0] int_gain_reg;
    logic signed [31:0] deriv_gain_reg;
    logic signed [15:0] out_min_reg;
    logic signed [15:0] out_max_reg;
    logic               p_on_meas_reg;
    logic               limits_written_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            int_gain_reg       <= '0;
            deriv_gain_reg     <= '0;
            out_min_reg        <= '0;
            out_max_reg        <= OUT_MAX_RESET;
            p_on_meas_reg      <= 1'b0;
            limits_written_reg <= 1'b0;
        end
        else
        begin
            limits_written_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (idx)
                    REG_PROP_GAIN:  prop_gain_reg  <= pwdata;
                    REG_INT_GAIN:   int_gain_reg   <= pwdata;
                    REG_DERIV_GAIN: deriv_gain_reg <= pwdata;
                    REG_OUT_MIN:
                    begin
                        out_min_reg        <= pwdata[15:0];
                        limits_written_reg <= 1'b1;
                    end
                    REG_OUT_MAX:
                    begin
                        out_max_reg        <= pwdata[15:0];
                        limits_written_reg <= 1'b1;
                    end
                    REG_P_ON_MEAS:  p_on_meas_reg  <= pwdata[0];
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PROP_GAIN:  prdata = prop_gain_reg;
            REG_INT_GAIN:   prdata = int_gain_reg;
            REG_DERIV_GAIN: prdata = deriv_gain_reg;
            REG_OUT_MIN:    prdata = {{16{out_min_reg[15]}}, out_min_reg};
            REG_OUT_MAX:    prdata = {{16{out_max_reg[15]}}, out_max_reg};
            REG_P_ON_MEAS:  prdata = {31'd0, p_on_meas_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.prop_gain        = prop_gain_reg;
    assign cfg.int_gain         = int_gain_reg;
    assign cfg.deriv_gain       = deriv_gain_reg;
    assign cfg.out_min          = out_min_reg;
    assign cfg.out_max          = out_max_reg;
    assign cfg.p_on_measurement = p_on_meas_reg;
    assign cfg.limits_written   = limits_written_reg;

endmodule

### rtl/pidcs_datapath.sv
module pidcs_datapath
    import pidcs_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_regs_t cfg,
    input  logic      step,
    input  sample_t   sample,
    output result_t   result
);

    localparam int F      = GAIN_FRAC_BITS;
    localparam int INT_W  = 24 + F;
    localparam int PROD_W = 49;
    localparam int ACC_W  = ((INT_W > PROD_W) ? INT_W : PROD_W) + 3;
    localparam int OUT_W  = ACC_W - F;
    localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic signed [INT_W-1:0]  integrator_reg;
    logic signed [15:0]       prev_meas_reg;
    logic                     was_auto_reg;

    logic signed [15:0]       meas;
    logic signed [15:0]       sp;
    logic signed [15:0]       manual;
    logic signed [15:0]       prev_eff;
    logic                     bump;
    logic                     limits_ok;
    logic signed [16:0]       err;
    logic signed [16:0]       dmeas;
    logic signed [PROD_W-1:0] ki_err;
    logic signed [PROD_W-1:0] kp_err;
    logic signed [PROD_W-1:0] kp_dm;
    logic signed [PROD_W-1:0] kd_dm;
    logic signed [ACC_W-1:0]  lo_q;
    logic signed [ACC_W-1:0]  hi_q;
    logic signed [ACC_W-1:0]  manual_q;
    logic signed [ACC_W-1:0]  integ_ext;
    logic signed [ACC_W-1:0]  integ_base;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  integ_new;
    logic signed [ACC_W-1:0]  integ_cfg;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  sum_half;
    logic signed [OUT_W-1:0]  rnd;
    logic signed [OUT_W-1:0]  lo_o;
    logic signed [OUT_W-1:0]  hi_o;
    logic signed [OUT_W-1:0]  y;
    logic                     hit;

    // upper limit checked first, so crossed limits give the upper one only above it
    function automatic logic signed [ACC_W-1:0] clamp_acc(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [ACC_W-1:0] r;
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r;
    endfunction

    assign meas      = sample.measurement;
    assign sp        = sample.setpoint;
    assign manual    = sample.manual_output;
    assign bump      = sample.auto_enable && !was_auto_reg;
    assign prev_eff  = bump ? meas : prev_meas_reg;
    assign limits_ok = cfg.out_min <= cfg.out_max;

    assign err   = {sp[15], sp} - {meas[15], meas};
    assign dmeas = {meas[15], meas} - {prev_eff[15], prev_eff};

    assign ki_err = PROD_W'(cfg.int_gain) * PROD_W'(err);
    assign kp_err = PROD_W'(cfg.prop_gain) * PROD_W'(err);
    assign kp_dm  = PROD_W'(cfg.prop_gain) * PROD_W'(dmeas);
    assign kd_dm  = PROD_W'(cfg.deriv_gain) * PROD_W'(dmeas);

    assign lo_q     = {{(ACC_W-16-F){cfg.out_min[15]}}, cfg.out_min, {F{1'b0}}};
    assign hi_q     = {{(ACC_W-16-F){cfg.out_max[15]}}, cfg.out_max, {F{1'b0}}};
    assign manual_q = {{(ACC_W-16-F){manual[15]}}, manual, {F{1'b0}}};
    assign integ_ext = ACC_W'(integrator_reg);

    // bumpless transfer loads the clamped manual output first
    assign integ_base = bump ? clamp_acc(manual_q, lo_q, hi_q) : integ_ext;

    always_comb
    begin
        acc = integ_base + ACC_W'(ki_err);
        if (cfg.p_on_measurement)
            acc = acc - ACC_W'(kp_dm);
    end

    assign integ_new = clamp_acc(acc, lo_q, hi_q);
    assign integ_cfg = clamp_acc(integ_ext, lo_q, hi_q);

    assign sum = (cfg.p_on_measurement ? '0 : ACC_W'(kp_err)) + integ_new - ACC_W'(kd_dm);

    // round half up: add a half then keep the integer bits
    assign sum_half = sum + HALF;
    assign rnd      = sum_half[ACC_W-1:F];
    assign lo_o     = OUT_W'(cfg.out_min);
    assign hi_o     = OUT_W'(cfg.out_max);

    always_comb
    begin
        if (rnd > hi_o)
        begin
            y   = hi_o;
            hit = 1'b1;
        end
        else if (rnd < lo_o)
        begin
            y   = lo_o;
            hit = 1'b1;
        end
        else
        begin
            y   = rnd;
            hit = 1'b0;
        end
    end

    always_comb
    begin
        if (sample.auto_enable)
        begin
            result.drive   = y[15:0];
            result.limited = hit;
        end
        else
        begin
            result.drive   = manual;
            result.limited = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integrator_reg <= '0;
            prev_meas_reg  <= '0;
            was_auto_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (sample.auto_enable)
            begin
                integrator_reg <= integ_new[INT_W-1:0];
                prev_meas_reg  <= meas;
                was_auto_reg   <= 1'b1;
            end
            else
            begin
                was_auto_reg <= 1'b0;
            end
        end
        else if (cfg.limits_written && limits_ok)
        begin
            integrator_reg <= integ_cfg[INT_W-1:0];
        end
    end

endmodule

### rtl/pid_controller_step_core.sv
// channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------
// sample    | sample_valid / sample_stall | measurement, setpoint, auto, manual
// result    | result_valid / result_stall | drive, limited
// config    | psel, penable, pwrite       | paddr, pwdata, prdata (pready high)
//
// one transaction per cycle sustained while result_stall is low; a sample goes
// through the input register, then one pass of multiply, integrator update and
// clamp into the output register; the integrator feedback closes in that pass
// rst_n clears control state, integrator, last measurement and config registers
// a stalled result holds in the output register while one more sample waits in
// the input register; sample_stall rises only when both are full
module pid_controller_step_core
    import pidcs_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_regs_t cfg;

    // input stage
    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t in_data_reg;

    // output stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;

    logic    advance;
    logic    step;
    logic    sample_take;

    pidcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidcs_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .sample (in_data_reg),
        .result (out_data_next)
    );

    // output register can take a new result when empty or being drained
    assign advance      = !out_valid_reg || !result_stall;
    assign step         = in_valid_reg && advance;
    assign sample_stall = in_valid_reg && !advance;
    assign sample_take  = sample_valid && !sample_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (sample_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (sample_take)
            in_data_reg <= sample;
        if (step)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // a clamped result always sits on one of the limits
    a_limited_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.limited |->
            (out_data_reg.drive == cfg.out_max) || (out_data_reg.drive == cfg.out_min))
        else $error("limited result not on a limit");

    // a step never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(out_valid_reg && result_stall))
        else $error("result overwritten while stalled");

    // every step leaves a result in the output register
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("step produced no result");

endmodule
